// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by byte_ring_buffer_top.
// The macros expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define BRB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define BRB_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define BRB_ASSERT(label, clk, rst, prop, msg)
`define BRB_NEVER(label, clk, rst, expr, msg)

`endif

`endif

// ===== src/brb_pkg.sv =====
// ----------------------------------------------------------------------------
// brb_pkg
// Shared constants and codes of the byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

   // storage and field sizes
   localparam int MaxDepth    = 1024;
   localparam int CapWidth    = 11;
   localparam int CapReset    = 1024;
   localparam int ByteWidth   = 8;
   localparam int KindWidth   = 3;
   localparam int StatusWidth = 2;

   // stream payload layout, padded to whole bytes
   localparam int ReqFields    = ByteWidth + CapWidth;
   localparam int ReqDataWidth = ((ReqFields + 7) / 8) * 8;
   localparam int RspFields    = ByteWidth + StatusWidth + 3 * CapWidth;
   localparam int RspDataWidth = ((RspFields + 7) / 8) * 8;
   localparam int RspPad       = RspDataWidth - RspFields;

   // operation codes carried in tuser
   typedef enum logic [KindWidth-1:0] {
      KIND_WRITE   = 3'd0,
      KIND_READ    = 3'd1,
      KIND_PEEK    = 3'd2,
      KIND_CONSUME = 3'd3,
      KIND_ADVANCE = 3'd4,
      KIND_CLEAR   = 3'd5
   } kind_type;

   // result status codes
   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_NO_DATA  = 2'd2
   } status_type;

endpackage

// ===== src/brb_ram.sv =====
// ----------------------------------------------------------------------------
// brb_ram
// Generic RAM, one write port and one read port, registered read data.
// Read data holds its value while no read is issued.
// ----------------------------------------------------------------------------
module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/byte_ring_buffer_top.sv =====
// ----------------------------------------------------------------------------
// byte_ring_buffer_top
// Circular byte FIFO over a single RAM: write, read, peek, consume, advance
// and clear, each answered by one status and occupancy report.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | tuser kind, tdata byte+amount
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata byte, status, runs
//  csr     | in        | csr_wen               | csr_wdata capacity
//
//  each operation passes an accept state and a finish state: the accept cycle
//  updates pointers and count and issues the RAM access, the finish state
//  forms the result from the registered RAM read data and the updated pointers
//  the result cycle waits while the output register is full and not taken
//  synchronous reset clears pointers and count; no clearing pass over the RAM
//  a capacity write clears the FIFO and is taken at once; no request
//  transfer is accepted in that cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module byte_ring_buffer_top #(
   parameter int MAX_DEPTH = brb_pkg::MaxDepth
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = data_byte[7:0], amount[18:8], zero pad
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [brb_pkg::ReqDataWidth-1:0]  req_tdata,
   // request: tuser = kind[2:0]
   input  logic [brb_pkg::KindWidth-1:0]     req_tuser,
   // response: tdata = data_out[7:0], status[9:8], fill_count[20:10],
   // contiguous_read[31:21], contiguous_write[42:32], zero pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [brb_pkg::RspDataWidth-1:0]  rsp_tdata,
   // capacity register
   input  logic                              csr_wen,
   input  logic [brb_pkg::CapWidth-1:0]      csr_wdata
);

   localparam int PW = $clog2(MAX_DEPTH);
   localparam int VW = (PW + 1 > brb_pkg::CapWidth) ? PW + 1 : brb_pkg::CapWidth;
   localparam logic [VW-1:0] MaxVal      = VW'(MAX_DEPTH);
   localparam logic [VW-1:0] CapResetVal = (brb_pkg::CapReset > MAX_DEPTH) ?
                                           VW'(MAX_DEPTH) : VW'(brb_pkg::CapReset);
   localparam int BW = brb_pkg::ByteWidth;
   localparam int CW = brb_pkg::CapWidth;

   typedef enum logic [1:0] {
      ST_ACCEPT = 2'b01,
      ST_FINISH = 2'b10
   } brb_state_type;

   brb_state_type       state_ff, state_in;
   logic [VW-1:0]       cap_ff, cap_in;
   logic [PW-1:0]       wp_ff, wp_in;
   logic [PW-1:0]       rp_ff, rp_in;
   logic [VW-1:0]       cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   brb_pkg::status_type pend_status_ff, pend_status_in;
   logic                pend_rd_ff, pend_rd_in;
   logic [brb_pkg::RspDataWidth-1:0] rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                rsp_load;
   brb_pkg::kind_type   kind;
   logic [BW-1:0]       data_byte;
   logic [VW-1:0]       amount;
   logic [VW-1:0]       rp_ext, wp_ext, space_left, csr_ext;
   logic [VW:0]         cap_x, rp_sum, wp_sum, rp_wrap, wp_wrap, exp_sum, exp_wrap;
   logic [VW-1:0]       rp_step, wp_step;
   logic [VW-1:0]       cap_m_rp, cap_m_wp, run_rd, run_wr;
   logic [BW-1:0]       dout;

   logic                ram_we, ram_re;
   logic [PW-1:0]       ram_raddr;
   logic [BW-1:0]       ram_rdata;

   // request fields
   assign kind      = brb_pkg::kind_type'(req_tuser);
   assign data_byte = req_tdata[BW-1:0];
   assign amount    = VW'(req_tdata[BW+CW-1:BW]);

   assign req_tready = (state_ff == ST_ACCEPT) && !csr_wen;
   assign accept     = req_tvalid & req_tready;
   assign rsp_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   // pointer arithmetic, one add and wrap per pointer
   assign rp_ext     = VW'(rp_ff);
   assign wp_ext     = VW'(wp_ff);
   assign space_left = cap_ff - cnt_ff;
   assign cap_x      = {1'b0, cap_ff};
   assign rp_step    = (kind == brb_pkg::KIND_READ)  ? VW'(1) : amount;
   assign wp_step    = (kind == brb_pkg::KIND_WRITE) ? VW'(1) : amount;
   assign rp_sum     = {1'b0, rp_ext} + {1'b0, rp_step};
   assign wp_sum     = {1'b0, wp_ext} + {1'b0, wp_step};
   assign rp_wrap    = (rp_sum >= cap_x) ? rp_sum - cap_x : rp_sum;
   assign wp_wrap    = (wp_sum >= cap_x) ? wp_sum - cap_x : wp_sum;

   // clamp of a written capacity to 1..MAX_DEPTH
   assign csr_ext = VW'(csr_wdata);

   // operation decode and state update
   always_comb begin
      state_in       = state_ff;
      cap_in         = cap_ff;
      wp_in          = wp_ff;
      rp_in          = rp_ff;
      cnt_in         = cnt_ff;
      pend_status_in = pend_status_ff;
      pend_rd_in     = pend_rd_ff;
      ram_we         = 1'b0;
      ram_re         = 1'b0;
      ram_raddr      = rp_ff;
      if (csr_wen) begin
         if (csr_ext == '0) begin
            cap_in = VW'(1);
         end else if (csr_ext > MaxVal) begin
            cap_in = MaxVal;
         end else begin
            cap_in = csr_ext;
         end
         wp_in  = '0;
         rp_in  = '0;
         cnt_in = '0;
      end else if (accept) begin
         state_in       = ST_FINISH;
         pend_status_in = brb_pkg::STATUS_OK;
         pend_rd_in     = 1'b0;
         case (kind)
            brb_pkg::KIND_WRITE: begin
               if (space_left == '0) begin
                  pend_status_in = brb_pkg::STATUS_NO_SPACE;
               end else begin
                  ram_we = 1'b1;
                  wp_in  = wp_wrap[PW-1:0];
                  cnt_in = cnt_ff + VW'(1);
               end
            end
            brb_pkg::KIND_READ: begin
               if (cnt_ff == '0) begin
                  pend_status_in = brb_pkg::STATUS_NO_DATA;
               end else begin
                  ram_re     = 1'b1;
                  pend_rd_in = 1'b1;
                  rp_in      = rp_wrap[PW-1:0];
                  cnt_in     = cnt_ff - VW'(1);
               end
            end
            brb_pkg::KIND_PEEK: begin
               if (amount >= cnt_ff) begin
                  pend_status_in = brb_pkg::STATUS_NO_DATA;
               end else begin
                  ram_re     = 1'b1;
                  pend_rd_in = 1'b1;
                  ram_raddr  = rp_wrap[PW-1:0];
               end
            end
            brb_pkg::KIND_CONSUME: begin
               if (amount > cnt_ff) begin
                  pend_status_in = brb_pkg::STATUS_NO_DATA;
               end else begin
                  rp_in  = rp_wrap[PW-1:0];
                  cnt_in = cnt_ff - amount;
               end
            end
            brb_pkg::KIND_ADVANCE: begin
               if (amount > space_left) begin
                  pend_status_in = brb_pkg::STATUS_NO_SPACE;
               end else begin
                  wp_in  = wp_wrap[PW-1:0];
                  cnt_in = cnt_ff + amount;
               end
            end
            brb_pkg::KIND_CLEAR: begin
               wp_in  = '0;
               rp_in  = '0;
               cnt_in = '0;
            end
            default: begin
            end
         endcase
      end
      // result moves into the output register
      if (rsp_load) begin
         state_in = ST_ACCEPT;
      end
   end

   // contiguous runs from the updated pointers
   assign cap_m_rp = cap_ff - rp_ext;
   assign cap_m_wp = cap_ff - wp_ext;

   always_comb begin
      if (cnt_ff == '0) begin
         run_rd = '0;
      end else if (cnt_ff == cap_ff || rp_ext >= wp_ext) begin
         run_rd = cap_m_rp;
      end else begin
         run_rd = wp_ext - rp_ext;
      end
   end

   always_comb begin
      if (space_left == '0) begin
         run_wr = '0;
      end else if (cnt_ff == '0) begin
         run_wr = cap_m_wp;
      end else if (wp_ext >= rp_ext) begin
         run_wr = (cap_m_wp < space_left) ? cap_m_wp : space_left;
      end else begin
         run_wr = rp_ext - wp_ext;
      end
   end

   // result assembly
   assign dout        = pend_rd_ff ? ram_rdata : '0;
   assign rsp_data_in = {{brb_pkg::RspPad{1'b0}}, run_wr[CW-1:0], run_rd[CW-1:0],
                         cnt_ff[CW-1:0], pend_status_ff, dout};

   // output register valid
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCEPT;
         cap_ff       <= CapResetVal;
         wp_ff        <= '0;
         rp_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_rd_ff     <= pend_rd_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // byte store
   brb_ram #(
      .WIDTH (BW),
      .DEPTH (MAX_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (data_byte),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // write pointer expected from read pointer plus count
   assign exp_sum  = {1'b0, rp_ext} + {1'b0, cnt_ff};
   assign exp_wrap = (exp_sum >= cap_x) ? exp_sum - cap_x : exp_sum;

   `BRB_ASSERT(a_cnt_within_cap, clock, reset, cnt_ff <= cap_ff, "count above capacity")
   `BRB_ASSERT(a_ptr_within_cap, clock, reset,
               (rp_ext < cap_ff) && (wp_ext < cap_ff), "pointer at or above capacity")
   `BRB_ASSERT(a_ptr_consistent, clock, reset, {1'b0, wp_ext} == exp_wrap,
               "write pointer disagrees with read pointer plus count")
   `BRB_ASSERT(a_hold_on_stall, clock, reset,
               (state_ff == ST_FINISH) && rsp_valid_ff && !rsp_tready
                  |=> (state_ff == ST_FINISH) && $stable(rsp_data_ff),
               "result overwritten while output stalled")
   `BRB_ASSERT(a_finish_loads, clock, reset,
               rsp_load |=> rsp_valid_ff && (state_ff == ST_ACCEPT),
               "result cycle did not load output")

endmodule
